// ===== rtl/gbfp_pkg.sv =====
// gbfp_pkg: shared constants and types for the binary gnss frame parser
// result item layout, queue status and configuration write bundle
// no dependencies
package gbfp_pkg;

    localparam int ACCEPT_ENTRIES_DEFAULT = 12;
    localparam int QUEUE_DEPTH            = 4;
    localparam int QUEUE_AW               = $clog2(QUEUE_DEPTH);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_MID  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_CNT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 3'd4;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd498;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // item kinds
    localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [2:0] KIND_GOOD     = 3'd1;
    localparam logic [2:0] KIND_BAD      = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd3;
    localparam logic [2:0] KIND_TOO_LONG = 3'd4;

    typedef struct packed {
        logic [2:0]  item_kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic        frame_end;
    } res_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

endpackage

// ===== rtl/gnss_binary_frame_parser.sv =====
// gnss_binary_frame_parser: sync/class/id/length/payload/fletcher-8 frame parser
// a result word is written into the result queue and then loaded into the output register before it is offered
// throughput: one byte per cycle while the result queue is not full, set by the byte-wide parser state machine
// a four-word result queue absorbs output stalls; input stalls only while it is full
// reset: parser hunts for sync, queue and output empty, config at reset values
// depends on gbfp_pkg, gbfp_front, gbfp_queue, gbfp_back
module gnss_binary_frame_parser #(
    parameter int ACCEPT_ENTRIES = gbfp_pkg::ACCEPT_ENTRIES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gbfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gbfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // rx_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // data_byte[7:0], byte_index[23:8], frame_class[31:24], frame_id[39:32],
    // frame_length[55:40]
    output logic [55:0]                       m_tdata,
    output logic [2:0]                        m_tuser,   // item_kind
    output logic                              m_tlast    // frame_end
);
    import gbfp_pkg::*;

    cfg_wr_t   cfg;
    q_stat_t   q_stat;
    res_item_t push_item;
    res_item_t head_item;
    logic      q_push;
    logic      q_pop;

    assign cfg_ready  = 1'b1;
    assign cfg.valid  = cfg_valid;
    assign cfg.index  = cfg_index;
    assign cfg.data   = cfg_data;

    gbfp_front #(
        .ACCEPT_ENTRIES (ACCEPT_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_item (push_item)
    );

    gbfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    gbfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // a word enters the queue only on an accepted byte and never into a full queue
    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (s_tvalid && s_tready && !q_stat.full))
        else $error("result pushed without an accepted byte or into a full queue");

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

    // only payload words leave with tlast low
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != KIND_PAYLOAD)))
        else $error("tlast does not match the item kind");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[23:0] == 24'd0))
        else $error("status word carries payload data or index");

endmodule

// ===== rtl/gbfp_front.sv =====
// gbfp_front: byte-wide frame parser with checksum, accept table and length check
// holds the configuration registers and pushes result items into the queue
// depends on gbfp_pkg
module gbfp_front #(
    parameter int ACCEPT_ENTRIES = gbfp_pkg::ACCEPT_ENTRIES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gbfp_pkg::cfg_wr_t     cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  gbfp_pkg::q_stat_t     q_stat,
    output logic                  push,
    output gbfp_pkg::res_item_t   push_item
);
    import gbfp_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_SYNC2  = 3'd1;
    localparam logic [2:0] PH_CLASS  = 3'd2;
    localparam logic [2:0] PH_ID     = 3'd3;
    localparam logic [2:0] PH_LEN_LO = 3'd4;
    localparam logic [2:0] PH_LEN_HI = 3'd5;
    localparam logic [2:0] PH_BODY   = 3'd6;

    logic [15:0] entry_reg [ACCEPT_ENTRIES];
    logic [3:0]  acc_cnt_reg;
    logic [15:0] max_len_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [16:0] body_reg, body_next;
    logic [7:0]  ck_a_reg, ck_a_next;

    logic [ACCEPT_ENTRIES-1:0] hit;
    logic        accepted;
    logic [7:0]  sa_add, sb_add;
    logic [15:0] new_len;
    logic        in_fire;

    // configuration writes
    for (genvar e = 0; e < ACCEPT_ENTRIES; e++) begin : g_entry
        localparam logic [CFG_INDEX_W-1:0] WORD_IDX = CFG_INDEX_W'(e / 4);
        localparam int LANE = (e % 4) * 16;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                entry_reg[e] <= '0;
            end
            else if (cfg.valid && cfg.index == REG_ACCEPT_LOW + WORD_IDX)
            begin
                entry_reg[e] <= cfg.data[LANE +: 16];
            end
        end
        // entry e is live when it lies below the configured count
        assign hit[e] = (4'(e) < acc_cnt_reg) && (entry_reg[e] == {class_reg, s_tdata});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg <= '0;
            max_len_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ACCEPT_CNT:  acc_cnt_reg <= cfg.data[3:0];
                REG_MAX_PAYLOAD: max_len_reg <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    assign accepted = (acc_cnt_reg == 4'd0) || (|hit);
    assign sa_add   = sum_a_reg + s_tdata;
    assign sb_add   = sum_b_reg + sa_add;
    assign new_len  = {s_tdata, len_reg[7:0]};
    assign s_tready = !q_stat.full;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        phase_next = phase_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        body_next  = body_reg;
        ck_a_next  = ck_a_reg;
        push       = 1'b0;
        push_item.item_kind    = KIND_PAYLOAD;
        push_item.data_byte    = '0;
        push_item.byte_index   = '0;
        push_item.frame_class  = class_reg;
        push_item.frame_id     = id_reg;
        push_item.frame_length = len_reg;
        push_item.frame_end    = 1'b1;

        if (in_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (s_tdata == SYNC_FIRST)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    // frame state is already clear while hunting
                    phase_next = (s_tdata == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
                end
                PH_CLASS:
                begin
                    sum_a_next = sa_add;
                    sum_b_next = sb_add;
                    class_next = s_tdata;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    if (accepted)
                    begin
                        sum_a_next = sa_add;
                        sum_b_next = sb_add;
                        id_next    = s_tdata;
                        phase_next = PH_LEN_LO;
                    end
                    else
                    begin
                        push = 1'b1;
                        push_item.item_kind    = KIND_UNKNOWN;
                        push_item.frame_id     = s_tdata;
                        push_item.frame_length = '0;
                        phase_next = PH_HUNT;
                        sum_a_next = '0;
                        sum_b_next = '0;
                        class_next = '0;
                    end
                end
                PH_LEN_LO:
                begin
                    sum_a_next = sa_add;
                    sum_b_next = sb_add;
                    len_next   = {8'd0, s_tdata};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    if (new_len > max_len_reg)
                    begin
                        push = 1'b1;
                        push_item.item_kind    = KIND_TOO_LONG;
                        push_item.frame_length = new_len;
                        phase_next = PH_HUNT;
                        sum_a_next = '0;
                        sum_b_next = '0;
                        class_next = '0;
                        id_next    = '0;
                        len_next   = '0;
                    end
                    else
                    begin
                        sum_a_next = sa_add;
                        sum_b_next = sb_add;
                        len_next   = new_len;
                        body_next  = '0;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (body_reg < {1'b0, len_reg})
                    begin
                        sum_a_next = sa_add;
                        sum_b_next = sb_add;
                        push = 1'b1;
                        push_item.item_kind  = KIND_PAYLOAD;
                        push_item.data_byte  = s_tdata;
                        push_item.byte_index = body_reg[15:0];
                        push_item.frame_end  = 1'b0;
                        body_next = body_reg + 17'd1;
                    end
                    else if (body_reg == {1'b0, len_reg})
                    begin
                        ck_a_next = s_tdata;
                        body_next = body_reg + 17'd1;
                    end
                    else
                    begin
                        push = 1'b1;
                        push_item.item_kind = (sum_a_reg == ck_a_reg && sum_b_reg == s_tdata)
                                              ? KIND_GOOD : KIND_BAD;
                        phase_next = PH_HUNT;
                        sum_a_next = '0;
                        sum_b_next = '0;
                        class_next = '0;
                        id_next    = '0;
                        len_next   = '0;
                        body_next  = '0;
                        ck_a_next  = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    sum_a_next = '0;
                    sum_b_next = '0;
                    class_next = '0;
                    id_next    = '0;
                    len_next   = '0;
                    body_next  = '0;
                    ck_a_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            class_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            body_reg  <= '0;
            ck_a_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            body_reg  <= body_next;
            ck_a_reg  <= ck_a_next;
        end
    end

endmodule

// ===== rtl/gbfp_queue.sv =====
// gbfp_queue: short result queue between the parser and the output stage
// small register array with read and write pointers and a fill count
// depends on gbfp_pkg
module gbfp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  gbfp_pkg::res_item_t   push_item,
    input  logic                  pop,
    output gbfp_pkg::res_item_t   head_item,
    output gbfp_pkg::q_stat_t     q_stat
);
    import gbfp_pkg::*;

    res_item_t            mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/gbfp_back.sv =====
// gbfp_back: output register that drains the result queue onto the master stream
// packs the result item into tdata, tuser and tlast
// depends on gbfp_pkg
module gbfp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gbfp_pkg::res_item_t   head_item,
    input  gbfp_pkg::q_stat_t     q_stat,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,
    output logic [2:0]            m_tuser,
    output logic                  m_tlast
);
    import gbfp_pkg::*;

    logic      valid_reg, valid_next;
    res_item_t item_reg;

    // refill whenever the register is empty or its word leaves this cycle
    assign pop = !q_stat.empty && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {item_reg.frame_length, item_reg.frame_id, item_reg.frame_class,
                       item_reg.byte_index, item_reg.data_byte};
    assign m_tuser  = item_reg.item_kind;
    assign m_tlast  = item_reg.frame_end;

endmodule

// ===== tb/gbfp_frame_checker.sv =====
// gbfp_frame_checker: watches the config, byte and result channels of the frame parser,
// predicts every result word from the accepted bytes and compares it with the output
// depends on gbfp_pkg
module gbfp_frame_checker
    import gbfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [55:0]            m_tdata,
    input  logic [2:0]             m_tuser,
    input  logic                   m_tlast,
    output int                     mismatch_count,
    output int                     items_outstanding
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_BODY
    } parse_phase_e;

    // parser copy
    parse_phase_e phase = PH_HUNT;
    logic [7:0]   ck_a, ck_b, ck_a_rx, cur_class, cur_id;
    logic [15:0]  cur_len;
    logic [16:0]  body_cnt;

    // register copy
    logic [63:0]  pairs_lo, pairs_mid, pairs_hi;
    logic [3:0]   n_accept;
    logic [15:0]  len_limit;

    res_item_t    pending_items[$];
    res_item_t    got, want;

    initial mismatch_count = 0;
    initial items_outstanding = 0;

    task automatic clear_frame();
        phase     = PH_HUNT;
        ck_a      = '0;
        ck_b      = '0;
        ck_a_rx   = '0;
        cur_class = '0;
        cur_id    = '0;
        cur_len   = '0;
        body_cnt  = '0;
    endtask

    task automatic fletcher(input logic [7:0] b);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
    endtask

    task automatic push_result(input logic [2:0] kind, input logic [7:0] data,
                               input logic [15:0] idx, input logic [15:0] len,
                               input logic last);
        res_item_t r;
        r.item_kind    = kind;
        r.data_byte    = data;
        r.byte_index   = idx;
        r.frame_class  = cur_class;
        r.frame_id     = cur_id;
        r.frame_length = len;
        r.frame_end    = last;
        pending_items.push_back(r);
    endtask

    function automatic bit pair_listed(input logic [7:0] c, input logic [7:0] i);
        int          n;
        logic [63:0] word;
        bit          hit;
        // counts above the table size saturate
        n   = (n_accept > ACCEPT_ENTRIES_DEFAULT) ? ACCEPT_ENTRIES_DEFAULT : int'(n_accept);
        hit = (n == 0);
        for (int k = 0; k < n; k++)
        begin
            word = (k < 4) ? pairs_lo : (k < 8) ? pairs_mid : pairs_hi;
            if (word[(k % 4) * 16 +: 16] == {c, i})
                hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b);
        case (phase)
            PH_HUNT:
                if (b == SYNC_FIRST)
                    phase = PH_SYNC2;
            PH_SYNC2:
            begin
                clear_frame();
                if (b == SYNC_SECOND)
                    phase = PH_CLASS;
            end
            PH_CLASS:
            begin
                fletcher(b);
                cur_class = b;
                phase     = PH_ID;
            end
            PH_ID:
            begin
                fletcher(b);
                cur_id = b;
                if (!pair_listed(cur_class, b))
                begin
                    push_result(KIND_UNKNOWN, 8'h00, 16'h0000, 16'h0000, 1'b1);
                    clear_frame();
                end
                else
                    phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                fletcher(b);
                cur_len = {8'h00, b};
                phase   = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                fletcher(b);
                cur_len[15:8] = b;
                if (cur_len > len_limit)
                begin
                    push_result(KIND_TOO_LONG, 8'h00, 16'h0000, cur_len, 1'b1);
                    clear_frame();
                end
                else
                begin
                    body_cnt = '0;
                    phase    = PH_BODY;
                end
            end
            PH_BODY:
            begin
                // payload, then ck_a, then ck_b closes the frame
                if (body_cnt < cur_len)
                begin
                    fletcher(b);
                    push_result(KIND_PAYLOAD, b, body_cnt[15:0], cur_len, 1'b0);
                    body_cnt = body_cnt + 1'b1;
                end
                else if (body_cnt == cur_len)
                begin
                    ck_a_rx  = b;
                    body_cnt = body_cnt + 1'b1;
                end
                else
                begin
                    push_result((ck_a == ck_a_rx && ck_b == b) ? KIND_GOOD : KIND_BAD,
                                8'h00, 16'h0000, cur_len, 1'b1);
                    clear_frame();
                end
            end
            default:
                clear_frame();
        endcase
    endtask

    function automatic string item_text(input res_item_t r);
        return $sformatf("kind=%0d data=%02h idx=%0d class=%02h id=%02h len=%0d end=%0b",
                         r.item_kind, r.data_byte, r.byte_index, r.frame_class,
                         r.frame_id, r.frame_length, r.frame_end);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            pairs_lo  = '0;
            pairs_mid = '0;
            pairs_hi  = '0;
            n_accept  = '0;
            len_limit = MAX_PAYLOAD_RESET;
            pending_items.delete();
            items_outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ACCEPT_LOW:  pairs_lo  = cfg_data;
                    REG_ACCEPT_MID:  pairs_mid = cfg_data;
                    REG_ACCEPT_HIGH: pairs_hi  = cfg_data;
                    REG_ACCEPT_CNT:  n_accept  = cfg_data[3:0];
                    REG_MAX_PAYLOAD: len_limit = cfg_data[15:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);

            if (m_tvalid && m_tready)
            begin
                got.item_kind    = m_tuser;
                got.data_byte    = m_tdata[7:0];
                got.byte_index   = m_tdata[23:8];
                got.frame_class  = m_tdata[31:24];
                got.frame_id     = m_tdata[39:32];
                got.frame_length = m_tdata[55:40];
                got.frame_end    = m_tlast;
                if (pending_items.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result word, expected none, got %s",
                             $time, item_text(got));
                end
                else
                begin
                    want = pending_items.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: result mismatch, expected %s, got %s",
                                 $time, item_text(want), item_text(got));
                    end
                end
            end

            items_outstanding <= pending_items.size();
        end
    end

endmodule

// ===== tb/gnss_binary_frame_parser_tb.sv =====
// gnss_binary_frame_parser_tb: drives bytes, config writes and output backpressure
// into the frame parser and reports the verdict from the frame checker
// depends on gbfp_pkg, gnss_binary_frame_parser, gbfp_frame_checker
module gnss_binary_frame_parser_tb;
    import gbfp_pkg::*;

    localparam int CK_OK    = 0;
    localparam int CK_BAD_A = 1;
    localparam int CK_BAD_B = 2;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [55:0]            m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;

    int                     mismatches;
    int                     outstanding;

    int                     snd_idle_pct  = 32;
    int                     rcv_idle_pct  = 80;
    int                     hold_request  = 0;
    int                     hold_left     = 0;

    // stimulus-side copy of the settings, used to shape frames
    logic [15:0]            table_entries [12];
    logic [3:0]             table_count = '0;
    logic [15:0]            cur_max     = MAX_PAYLOAD_RESET;

    gnss_binary_frame_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    gbfp_frame_checker u_frame_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .mismatch_count    (mismatches),
        .items_outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // sender stops until every result is back, then lets the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_settings();
        logic [63:0] w [3];
        for (int k = 0; k < 12; k++)
            w[k / 4][(k % 4) * 16 +: 16] = table_entries[k];
        write_reg(REG_ACCEPT_LOW, w[0]);
        write_reg(REG_ACCEPT_MID, w[1]);
        write_reg(REG_ACCEPT_HIGH, w[2]);
        write_reg(REG_ACCEPT_CNT, {60'd0, table_count});
        write_reg(REG_MAX_PAYLOAD, {48'd0, cur_max});
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_settings();
        for (int k = 0; k < 12; k++)
            table_entries[k] = 16'($urandom_range(16'hFFFF));
        case ($urandom_range(4))
            0:       table_count = 4'd0;
            1:       table_count = 4'd15;
            default: table_count = 4'($urandom_range(1, 12));
        endcase
        case ($urandom_range(3))
            0:       cur_max = MAX_PAYLOAD_RESET;
            1:       cur_max = 16'($urandom_range(16, 64));
            2:       cur_max = 16'hFFFF;
            default: cur_max = 16'($urandom_range(0, 15));
        endcase
    endtask

    function automatic logic [15:0] accepted_pair();
        int n;
        n = (table_count > 12) ? 12 : int'(table_count);
        if (n == 0)
            return 16'($urandom_range(16'hFFFF));
        return table_entries[$urandom_range(n - 1)];
    endfunction

    // mostly short payloads, now and then the largest allowed one
    function automatic int pick_len();
        if (cur_max <= MAX_PAYLOAD_RESET && $urandom_range(39) == 0)
            return cur_max;
        return $urandom_range(0, (cur_max < 20) ? cur_max : 20);
    endfunction

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input int ck_err);
        logic [7:0] sa, sb, p;
        logic [7:0] hdr [4];
        sa     = '0;
        sb     = '0;
        hdr[0] = cls;
        hdr[1] = id;
        hdr[2] = len[7:0];
        hdr[3] = len[15:8];
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (int k = 0; k < 4; k++)
        begin
            sa += hdr[k];
            sb += sa;
            send_byte(hdr[k]);
        end
        // oversized frames are dropped at the length, no body follows
        if (len > cur_max)
            return;
        for (int k = 0; k < len; k++)
        begin
            p  = 8'($urandom_range(255));
            sa += p;
            sb += sa;
            send_byte(p);
        end
        if (ck_err == CK_BAD_A)
            sa ^= 8'h01 << $urandom_range(7);
        if (ck_err == CK_BAD_B)
            sb ^= 8'h01 << $urandom_range(7);
        send_byte(sa);
        send_byte(sb);
    endtask

    task automatic random_traffic(input int budget);
        int          sel, len, ck, junk;
        logic [15:0] pair;
        logic [7:0]  b;
        while (budget > 0)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                pair = accepted_pair();
                len  = pick_len();
                ck   = ($urandom_range(9) == 0) ? $urandom_range(CK_BAD_A, CK_BAD_B) : CK_OK;
                send_frame(pair[15:8], pair[7:0], 16'(len), ck);
                budget -= len + 8;
            end
            else if (sel < 80)
            begin
                len = pick_len();
                send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 16'(len), CK_OK);
                budget -= len + 8;
            end
            else if (sel < 88 && cur_max != 16'hFFFF)
            begin
                pair = accepted_pair();
                len  = cur_max + 1 + $urandom_range(0, 65534 - cur_max);
                send_frame(pair[15:8], pair[7:0], 16'(len), CK_OK);
                budget -= 6;
            end
            else if (sel < 94)
            begin
                // sync start followed by a wrong second byte
                send_byte(SYNC_FIRST);
                do
                    b = ($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom_range(255));
                while (b == SYNC_SECOND);
                send_byte(b);
                budget -= 2;
            end
            else
            begin
                junk = $urandom_range(1, 6);
                repeat (junk)
                    send_byte(8'($urandom_range(255)));
                budget -= junk;
            end
        end
    endtask

    initial
    begin
        logic [15:0] lead_pair;
        for (int k = 0; k < 12; k++)
            table_entries[k] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: every pair accepted, limit 498
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_frame(8'h00, 8'hFF, 16'd0, CK_OK);
        send_frame(8'hFF, 8'h00, 16'd3, CK_OK);
        send_frame(8'h01, 8'h07, 16'd2, CK_BAD_A);
        send_frame(8'h01, 8'h07, 16'd1, CK_BAD_B);
        send_frame(8'h0A, 8'h04, 16'd499, CK_OK);
        wait_idle();

        // full table with a saturating count, zero payload limit
        for (int k = 0; k < 12; k++)
            table_entries[k] = 16'(16'h0101 * k);
        table_entries[11] = 16'hFFFF;
        table_count = 4'd15;
        cur_max     = 16'd0;
        apply_settings();
        send_frame(8'hFF, 8'hFF, 16'd0, CK_OK);
        send_frame(8'h00, 8'h00, 16'd1, CK_OK);
        send_frame(8'h12, 8'h34, 16'd0, CK_OK);
        wait_idle();

        table_count = 4'd1;
        cur_max     = 16'hFFFF;
        apply_settings();
        send_frame(8'h00, 8'h00, 16'd2, CK_OK);
        send_frame(8'h01, 8'h01, 16'd2, CK_OK);
        wait_idle();

        table_count = 4'd0;
        cur_max     = 16'hFFFE;
        apply_settings();
        send_frame(8'h5A, 8'hA5, 16'hFFFF, CK_OK);
        wait_idle();

        for (int ph = 0; ph < 3; ph++)
        begin
            pick_settings();
            case (ph)
                0:
                begin
                    snd_idle_pct = 32;
                    rcv_idle_pct = 80;
                end
                1:
                begin
                    snd_idle_pct = 80;
                    rcv_idle_pct = 32;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    cur_max      = MAX_PAYLOAD_RESET;
                end
            endcase
            apply_settings();
            if (ph == 2)
            begin
                // long output hold-off while a long frame keeps coming: queue fills
                hold_request = 300;
                lead_pair    = accepted_pair();
                send_frame(lead_pair[15:8], lead_pair[7:0], 16'd40, CK_OK);
            end
            random_traffic(270);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
